[hw/rtl/prfw_pkg.sv]
// ----------------------------------------------------------------------------
// prfw_pkg
// Types and constants shared by the prime field word ALU.
// ----------------------------------------------------------------------------
package prfw_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_INV = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [WORD_W-1:0] elem;
    logic [WORD_W-1:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              error;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_ECHK,
    S_EDIV,
    S_MUL,
    S_DONE
  } core_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

[hw/rtl/prfw_core.sv]
// ----------------------------------------------------------------------------
// prfw_core
// Bit-serial sequencer: operand reduction, extended Euclid, shift-add product.
// ----------------------------------------------------------------------------
module prfw_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  prfw_pkg::in_word_t            in_word,
  input  logic [prfw_pkg::WORD_W-1:0]   modulus,
  input  logic                          ack,
  output prfw_pkg::core_stat_t          stat,
  output prfw_pkg::out_word_t           res
);
  import prfw_pkg::*;

  localparam int unsigned W = WORD_W;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(W - 1);
  localparam logic [W-1:0] ONE = W'(1);

  core_state_t state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [W-1:0]     m_r, m_nxt;
  logic [W-1:0]     sha_r, sha_nxt, shb_r, shb_nxt;
  logic [W-1:0]     rema_r, rema_nxt, remb_r, remb_nxt;
  logic [W-1:0]     r0_r, r0_nxt, r1_r, r1_nxt;
  logic [W-1:0]     t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0]     acc_r, acc_nxt, x_r, x_nxt, a_r, a_nxt;
  logic [W-1:0]     res_r, res_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W-1:0] red_a, red_b, div_rem, acc_div, acc_mul, acc_dbl;
  logic [W:0]   div_t;
  logic         div_q, last;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  function automatic logic [W-1:0] sub_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    return (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  function automatic logic [W-1:0] rstep(logic [W-1:0] r, logic b, logic [W-1:0] d);
    logic [W:0] t;
    t = {r, b};
    return (t >= {1'b0, d}) ? W'(t - {1'b0, d}) : t[W-1:0];
  endfunction

  always_comb begin
    last    = (cnt_r == '0);
    red_a   = rstep(rema_r, sha_r[W-1], m_r);
    red_b   = rstep(remb_r, shb_r[W-1], m_r);
    div_t   = {rema_r, sha_r[W-1]};
    div_q   = (div_t >= {1'b0, r1_r});
    div_rem = div_q ? W'(div_t - {1'b0, r1_r}) : div_t[W-1:0];
    acc_dbl = add_mod(acc_r, acc_r, m_r);
    acc_div = div_q ? add_mod(acc_dbl, t1_r, m_r) : acc_dbl;
    acc_mul = shb_r[W-1] ? add_mod(acc_dbl, x_r, m_r) : acc_dbl;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (modulus < W'(2)) ? S_DONE : S_RED;
      end
      S_RED: begin
        if (last) begin
          unique case (op_r)
            CMD_MUL:          state_nxt = S_MUL;
            CMD_DIV, CMD_INV: state_nxt = S_ECHK;
            default:          state_nxt = S_DONE;
          endcase
        end
      end
      S_ECHK: begin
        if (r1_r != '0)                          state_nxt = S_EDIV;
        else if (r0_r == ONE && op_r == CMD_DIV) state_nxt = S_MUL;
        else                                     state_nxt = S_DONE;
      end
      S_EDIV: if (last) state_nxt = S_ECHK;
      S_MUL:  if (last) state_nxt = S_DONE;
      S_DONE: if (ack) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt = op_r; m_nxt = m_r; sha_nxt = sha_r; shb_nxt = shb_r;
    rema_nxt = rema_r; remb_nxt = remb_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; acc_nxt = acc_r; x_nxt = x_r; a_nxt = a_r;
    res_nxt = res_r; err_nxt = err_r; cnt_nxt = cnt_r - CNT_W'(1);
    unique case (state_r)
      S_IDLE: begin
        op_nxt   = in_word.cmd;
        m_nxt    = modulus;
        sha_nxt  = in_word.elem;
        shb_nxt  = in_word.operand;
        rema_nxt = '0;
        remb_nxt = '0;
        cnt_nxt  = CNT_TOP;
        res_nxt  = '0;
        err_nxt  = (modulus < W'(2));
      end
      S_RED: begin
        rema_nxt = red_a;
        remb_nxt = red_b;
        sha_nxt  = sha_r << 1;
        shb_nxt  = shb_r << 1;
        if (last) begin
          cnt_nxt = CNT_TOP;
          acc_nxt = '0;
          r0_nxt  = m_r;
          t0_nxt  = '0;
          t1_nxt  = ONE;
          unique case (op_r)
            CMD_ADD: res_nxt = add_mod(red_a, red_b, m_r);
            CMD_SUB: res_nxt = sub_mod(red_a, red_b, m_r);
            CMD_MUL: begin
              x_nxt   = red_a;
              shb_nxt = red_b;
            end
            CMD_DIV: begin
              a_nxt  = red_a;
              r1_nxt = red_b;
            end
            CMD_INV: r1_nxt = red_a;
            default: res_nxt = '0;
          endcase
        end
      end
      S_ECHK: begin
        cnt_nxt = CNT_TOP;
        acc_nxt = '0;
        if (r1_r != '0) begin
          sha_nxt  = r0_r;
          rema_nxt = '0;
        end else if (r0_r != ONE) begin
          err_nxt = 1'b1;
          res_nxt = '0;
        end else if (op_r == CMD_DIV) begin
          x_nxt   = a_r;
          shb_nxt = t0_r;
        end else begin
          res_nxt = t0_r;
        end
      end
      S_EDIV: begin
        sha_nxt  = sha_r << 1;
        rema_nxt = div_rem;
        acc_nxt  = acc_div;
        if (last) begin
          r0_nxt = r1_r;
          r1_nxt = div_rem;
          t0_nxt = t1_r;
          t1_nxt = sub_mod(t0_r, acc_div, m_r);
        end
      end
      S_MUL: begin
        acc_nxt = acc_mul;
        shb_nxt = shb_r << 1;
        if (last) res_nxt = acc_mul;
      end
      S_DONE: cnt_nxt = cnt_r;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // outputs
  always_comb begin
    stat.idle  = (state_r == S_IDLE);
    stat.done  = (state_r == S_DONE);
    res.result = res_r;
    res.error  = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r <= op_nxt; m_r <= m_nxt; sha_r <= sha_nxt; shb_r <= shb_nxt;
    rema_r <= rema_nxt; remb_r <= remb_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; acc_r <= acc_nxt; x_r <= x_nxt;
    a_r <= a_nxt; res_r <= res_nxt; err_r <= err_nxt;
  end

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !err_r) |-> (res_r < m_r))
    else $error("result not below modulus");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && err_r) |-> (res_r == '0))
    else $error("error word with nonzero result");

  a_euclid_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIV) |-> (r1_r < r0_r && t1_r < m_r))
    else $error("remainder sequence out of order");

endmodule

[hw/rtl/prime_field_word_alu.sv]
// ----------------------------------------------------------------------------
// prime_field_word_alu
// Add, subtract, multiply, divide and invert in GF(p), one word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data writes the modulus; cfg_ready is always high.
//   in_valid/in_ready take one word {cmd, elem, operand}; out_valid/out_ready
//   hand back {result, error}. One word is worked on at a time.
// Sequence, W = 32 bit word:
//   modulus below two: error word, no reduction pass.  add, subtract, unused
//   codes: reduction pass.  multiply: reduction and shift-add passes.  invert:
//   reduction pass and k Euclid steps (k up to about 1.44W + 2).  divide:
//   invert plus a shift-add pass.  Every step is one bit-serial pass
//   through the reduction, division or shift-add loop.
// Reset sets the modulus to 2 and empties the core and output register.
// The output register holds a finished word while out_ready is low; the core
// then takes the next word and holds its own result until the register frees.
// ----------------------------------------------------------------------------
module prime_field_word_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prfw_pkg::WORD_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  prfw_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output prfw_pkg::out_word_t          out_word
);
  import prfw_pkg::*;

  logic [WORD_W-1:0] modulus_r, modulus_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;
  core_stat_t        stat;
  out_word_t         core_res;
  logic              load;

  prfw_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid & in_ready),
    .in_word (in_word),
    .modulus (modulus_r),
    .ack     (load),
    .stat    (stat),
    .res     (core_res)
  );

  always_comb begin
    cfg_ready     = 1'b1;
    in_ready      = stat.idle;
    load          = stat.done & (~out_valid_r | out_ready);
    modulus_nxt   = (cfg_valid) ? cfg_data : modulus_r;
    out_valid_nxt = load | (out_valid_r & ~out_ready);
    out_word_nxt  = load ? core_res : out_word_r;
    out_valid     = out_valid_r;
    out_word      = out_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= WORD_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

endmodule
